// ===== src/tree_routing_node_engine_core_defines.svh =====
// Assertion helpers for the routing node engine.
`ifndef TREE_ROUTING_NODE_ENGINE_CORE_DEFINES_SVH
`define TREE_ROUTING_NODE_ENGINE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TRN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TRN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TRN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/trn_pkg.sv =====
package trn_pkg;

  typedef enum logic [1:0] {
    ACT_UNI_RX  = 2'd0,
    ACT_UNI_TMO = 2'd1,
    ACT_BC_RX   = 2'd2,
    ACT_NONE    = 2'd3
  } trn_act_t;

  typedef enum logic [1:0] {
    MSG_REPORT = 2'd0,
    MSG_VALVE  = 2'd1,
    MSG_SAVE   = 2'd2,
    MSG_LOST   = 2'd3
  } trn_msg_t;

  localparam logic [1:0] BC_INFO    = 2'd0;
  localparam logic [1:0] BC_REQUEST = 2'd1;

  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_UNI  = 2'd1;
  localparam logic [1:0] SEND_BC   = 2'd2;

  localparam logic CFG_OWN_ADDR   = 1'b0;
  localparam logic CFG_SIG_OFFSET = 1'b1;

  localparam logic [15:0]        RANK_NONE   = 16'd32767;
  localparam logic signed [16:0] SIGNAL_NONE = -17'sd32767;
  localparam logic signed [7:0]  OFFSET_RST  = -8'sd45;
  localparam int                 MaxResults  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HSCAN,
    ST_DISPATCH,
    ST_CSCAN,
    ST_FINISH,
    ST_SAVE,
    ST_EMIT
  } trn_state_t;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_VALVE,
    OP_LOST,
    OP_TIMEOUT
  } trn_op_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [15:0]       peer_address;
    logic [7:0]        sequence_number;
    logic [1:0]        message_type;
    logic [15:0]       source_address;
    logic [15:0]       target_address;
    logic [15:0]       lost_address;
    logic [14:0]       sender_rank;
    logic signed [7:0] raw_signal;
    logic [31:0]       time_now;
  } trn_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] hop_addr;
    logic [1:0]  out_type;
    logic [15:0] out_target;
    logic [15:0] out_source;
    logic [15:0] out_lost;
    logic [14:0] out_rank;
    logic        valve_command;
    logic        duplicate;
    logic        last;
  } trn_res_t;

  typedef struct packed {
    logic wr_new;
    logic wr_stamp;
    logic inv;
    logic clr;
  } trn_cctl_t;

  function automatic trn_res_t trn_uni(logic [15:0] hop, logic [1:0] typ,
                                       logic [15:0] tgt, logic [15:0] src,
                                       logic [15:0] lost);
    trn_res_t r;
    r = '0;
    r.send_kind  = SEND_UNI;
    r.hop_addr   = hop;
    r.out_type   = typ;
    r.out_target = tgt;
    r.out_source = src;
    r.out_lost   = lost;
    return r;
  endfunction

endpackage

// ===== src/trn_in_if.sv =====
interface trn_in_if import trn_pkg::*; ();
  logic      valid;
  logic      ready;
  trn_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/trn_out_if.sv =====
interface trn_out_if import trn_pkg::*; ();
  logic     valid;
  logic     ready;
  trn_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/tree_routing_node_engine_core.sv =====
// Tree routing node engine: duplicate filter, child table and parent tracking.
// Flow: a broadcast passes dispatch and emit before its word is registered; a unicast
// from a new sender passes the history scan, dispatch, the child scan, finish and
// emit; save orders leave one a cycle while the output is not stalled.
// Throughput: one event at a time; ready returns the cycle after the final word is
// pushed; an output stall holds back that final push.
// Reset (synchronous, rst_n low): all valid bits, rank, parent and filter
// pointer return to their idle values; no clearing pass is needed.
`include "tree_routing_node_engine_core_defines.svh"
module tree_routing_node_engine_core import trn_pkg::*; #(
  parameter int HISTORY_DEPTH = 8,
  parameter int CHILD_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  trn_in_if.sink      in_ch,
  trn_out_if.source   out_ch
);
  localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HSW = $clog2(HISTORY_DEPTH + 1);
  localparam int CIW = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
  localparam int CSW = $clog2(CHILD_DEPTH + 1);
  localparam int RCW = $clog2(MaxResults + 1);

  // Configuration registers.
  logic [15:0]       own_r;
  logic signed [7:0] offs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= '0;
      offs_r <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDR:   own_r  <= cfg_wdata;
        CFG_SIG_OFFSET: offs_r <= cfg_wdata[7:0];
        default:        own_r  <= own_r;
      endcase
    end
  end

  // Control and working state.
  trn_state_t        state_r, state_nxt;
  trn_item_t         item_r;
  trn_op_t           op_r;
  logic [15:0]       key_r;
  logic [HSW-1:0]    hidx_r;
  logic [CSW-1:0]    cidx_r;
  logic              hit_r, free_r;
  logic [CIW-1:0]    hit_idx_r, free_idx_r;
  logic              hold_v_r;
  trn_res_t          hold_r;
  logic [RCW-1:0]    sent_r;
  logic [15:0]       save_src_r, save_lost_r;
  logic [15:0]       parent_r;
  logic [15:0]       rank_r;
  logic signed [16:0] psig_r;
  logic [HIW-1:0]    oldest_r;
  logic              out_valid_r;
  trn_res_t          out_r;

  // History row.
  logic [HISTORY_DEPTH-1:0] h_valid;
  logic [15:0]              h_sender [HISTORY_DEPTH];
  logic [7:0]               h_seq    [HISTORY_DEPTH];
  logic                     hw_en;
  logic [HIW-1:0]           hw_idx;

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
    trn_hist_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (hw_en && (hw_idx == HIW'(g))),
      .wr_sender (item_r.peer_address),
      .wr_seq    (item_r.sequence_number),
      .valid     (h_valid[g]),
      .sender    (h_sender[g]),
      .seq       (h_seq[g])
    );
  end

  // Child row.
  logic [CHILD_DEPTH-1:0] c_valid;
  logic [15:0]            c_addr [CHILD_DEPTH];
  logic [15:0]            c_hop  [CHILD_DEPTH];
  trn_cctl_t              cctl   [CHILD_DEPTH];

  for (genvar g = 0; g < CHILD_DEPTH; g++) begin : g_child
    trn_child_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cctl[g]),
      .wr_addr  (item_r.source_address),
      .wr_hop   (item_r.peer_address),
      .wr_stamp (item_r.time_now),
      .valid    (c_valid[g]),
      .addr     (c_addr[g]),
      .hop      (c_hop[g])
    );
  end

  // Scan taps.
  logic [HIW-1:0]    h_sel;
  logic [CIW-1:0]    c_sel;
  logic              hend, cend, h_match, c_valid_sel, c_match, c_save;
  logic              out_free, accept;
  logic signed [7:0] bsig8;
  logic signed [16:0] bsig, vsig;

  assign h_sel       = hidx_r[HIW-1:0];
  assign c_sel       = cidx_r[CIW-1:0];
  assign hend        = (hidx_r == HSW'(HISTORY_DEPTH));
  assign cend        = (cidx_r == CSW'(CHILD_DEPTH));
  assign h_match     = h_valid[h_sel] && (h_sender[h_sel] == item_r.peer_address);
  assign c_valid_sel = c_valid[c_sel];
  assign c_match     = c_valid_sel && (c_addr[c_sel] == key_r);
  assign c_save      = c_valid_sel && (c_addr[c_sel] == c_hop[c_sel]) &&
                       (sent_r < RCW'(MaxResults));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign bsig8       = item_r.raw_signal + offs_r;
  assign bsig        = {{9{bsig8[7]}}, bsig8};
  assign vsig        = {{9{item_r.raw_signal[7]}}, item_r.raw_signal} +
                       {{9{offs_r[7]}}, offs_r};

  // Words staged without a table scan: a dropped repeat, a valve for this node
  // and the broadcast reply.
  trn_res_t dup_res, disp_res;

  always_comb begin
    dup_res           = '0;
    dup_res.duplicate = 1'b1;
    disp_res          = '0;
    if (item_r.action == ACT_UNI_RX && item_r.message_type == MSG_VALVE) begin
      disp_res.valve_command = 1'b1;
    end
    if (item_r.action == ACT_BC_RX) begin
      disp_res.send_kind  = SEND_BC;
      disp_res.out_source = own_r;
      disp_res.out_rank   = rank_r[14:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.data.action == ACT_UNI_RX) ? ST_HSCAN : ST_DISPATCH;
        end
      end
      ST_HSCAN: begin
        if (hend) begin
          state_nxt = ST_DISPATCH;
        end else if (h_match) begin
          state_nxt = (h_seq[h_sel] == item_r.sequence_number) ? ST_EMIT : ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (item_r.action == ACT_UNI_RX) begin
          priority if (item_r.message_type == MSG_SAVE) begin
            state_nxt = ST_SAVE;
          end else if (item_r.message_type == MSG_VALVE &&
                       item_r.target_address == own_r) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CSCAN;
          end
        end else if (item_r.action == ACT_UNI_TMO) begin
          state_nxt = (item_r.peer_address != parent_r) ? ST_CSCAN : ST_SAVE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CSCAN: if (cend) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_EMIT;
      ST_SAVE: if (cend) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  logic     push;
  trn_res_t push_data;
  logic     save_stall;

  assign save_stall = c_save && hold_v_r && !out_free;

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    push        = 1'b0;
    push_data   = hold_r;
    hw_en       = 1'b0;
    hw_idx      = oldest_r;
    for (int i = 0; i < CHILD_DEPTH; i++) begin
      cctl[i] = '0;
    end
    unique case (state_r)
      ST_HSCAN: begin
        if (hend) begin
          hw_en = 1'b1;
        end else if (h_match && h_seq[h_sel] != item_r.sequence_number) begin
          hw_en  = 1'b1;
          hw_idx = h_sel;
        end
      end
      ST_FINISH: begin
        unique case (op_r)
          OP_REPORT: begin
            if (hit_r) cctl[hit_idx_r].wr_stamp = 1'b1;
            else if (free_r) cctl[free_idx_r].wr_new = 1'b1;
          end
          OP_LOST, OP_TIMEOUT: if (hit_r) cctl[hit_idx_r].inv = 1'b1;
          default: ;
        endcase
      end
      ST_SAVE: begin
        if (cend) begin
          for (int i = 0; i < CHILD_DEPTH; i++) begin
            cctl[i].clr = 1'b1;
          end
        end else if (c_save && hold_v_r && out_free) begin
          push           = 1'b1;
          push_data.last = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          push           = 1'b1;
          push_data      = hold_v_r ? hold_r : '0;
          push_data.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
      parent_r <= '0;
      rank_r   <= RANK_NONE;
      psig_r   <= SIGNAL_NONE;
      oldest_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          hold_v_r <= 1'b0;
        end
        ST_HSCAN: begin
          if (hend) begin
            oldest_r <= (oldest_r == HIW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
          end else if (h_match && h_seq[h_sel] == item_r.sequence_number) begin
            hold_v_r <= 1'b1;
          end
        end
        ST_DISPATCH: begin
          if (item_r.action == ACT_UNI_RX && item_r.message_type == MSG_VALVE) begin
            psig_r <= vsig;
            if (item_r.target_address == own_r) hold_v_r <= 1'b1;
          end
          if (item_r.action == ACT_BC_RX) begin
            if (item_r.message_type == BC_INFO && bsig > psig_r &&
                ({1'b0, item_r.sender_rank} + 16'd1) < rank_r) begin
              rank_r   <= {1'b0, item_r.sender_rank} + 16'd1;
              psig_r   <= bsig;
              parent_r <= item_r.source_address;
            end
            if (item_r.message_type == BC_REQUEST && rank_r != RANK_NONE) begin
              hold_v_r <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (op_r != OP_TIMEOUT || hit_r) hold_v_r <= 1'b1;
        end
        ST_SAVE: begin
          if (cend) begin
            rank_r <= RANK_NONE;
            psig_r <= SIGNAL_NONE;
          end else if (c_save && !save_stall) begin
            hold_v_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        item_r <= in_ch.data;
        hidx_r <= '0;
        cidx_r <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        sent_r <= '0;
      end
      ST_HSCAN: begin
        hidx_r <= hidx_r + 1'b1;
        hold_r <= dup_res;
      end
      ST_DISPATCH: begin
        hold_r <= disp_res;
        if (item_r.action == ACT_UNI_TMO) begin
          op_r        <= OP_TIMEOUT;
          key_r       <= item_r.peer_address;
          save_src_r  <= own_r;
          save_lost_r <= '0;
        end else begin
          save_src_r  <= item_r.source_address;
          save_lost_r <= item_r.lost_address;
          if (item_r.message_type == MSG_REPORT) begin
            op_r  <= OP_REPORT;
            key_r <= item_r.source_address;
          end else if (item_r.message_type == MSG_VALVE) begin
            op_r  <= OP_VALVE;
            key_r <= item_r.target_address;
          end else begin
            op_r  <= OP_LOST;
            key_r <= item_r.lost_address;
          end
        end
      end
      ST_CSCAN: begin
        cidx_r <= cidx_r + 1'b1;
        if (c_match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= c_sel;
        end
        if (!c_valid_sel && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= c_sel;
        end
      end
      ST_FINISH: begin
        unique case (op_r)
          OP_REPORT: hold_r <= trn_uni(parent_r, MSG_REPORT, parent_r,
                                       item_r.source_address, item_r.lost_address);
          OP_VALVE: hold_r <= trn_uni(hit_r ? c_hop[hit_idx_r] : parent_r, MSG_VALVE,
                                      item_r.target_address, item_r.source_address,
                                      item_r.lost_address);
          OP_LOST: hold_r <= trn_uni(parent_r, MSG_LOST, item_r.target_address,
                                     item_r.source_address, item_r.lost_address);
          default: hold_r <= trn_uni(parent_r, MSG_LOST, parent_r, own_r,
                                     item_r.peer_address);
        endcase
      end
      ST_SAVE: begin
        // Hold the newest order back so the final one can carry last.
        if (!cend && !save_stall) begin
          cidx_r <= cidx_r + 1'b1;
          if (c_save) begin
            sent_r <= sent_r + 1'b1;
            hold_r <= trn_uni(c_hop[c_sel], MSG_SAVE, c_addr[c_sel],
                              save_src_r, save_lost_r);
          end
        end
      end
      default: ;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_r <= push_data;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `TRN_ASSERT_IMP(a_idle_no_hold, clk, rst_n, in_ch.ready, state_r == ST_IDLE)
  `TRN_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, !in_ch.ready)
  `TRN_ASSERT_IMP(a_rank_range, clk, rst_n, 1'b1, rank_r <= RANK_NONE)
  `TRN_ASSERT_IMP(a_push_free, clk, rst_n, push, out_free)
endmodule

// ===== src/trn_hist_cell.sv =====
module trn_hist_cell import trn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [15:0] wr_sender,
  input  logic [7:0]  wr_seq,
  output logic        valid,
  output logic [15:0] sender,
  output logic [7:0]  seq
);
  logic        valid_r;
  logic [15:0] sender_r;
  logic [7:0]  seq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sender_r <= wr_sender;
      seq_r    <= wr_seq;
    end
  end

  assign valid  = valid_r;
  assign sender = sender_r;
  assign seq    = seq_r;
endmodule

// ===== src/trn_child_cell.sv =====
module trn_child_cell import trn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  trn_cctl_t   ctl,
  input  logic [15:0] wr_addr,
  input  logic [15:0] wr_hop,
  input  logic [31:0] wr_stamp,
  output logic        valid,
  output logic [15:0] addr,
  output logic [15:0] hop
);
  logic        valid_r;
  logic [15:0] addr_r;
  logic [15:0] hop_r;
  logic [31:0] stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr || ctl.inv) begin
      valid_r <= 1'b0;
    end else if (ctl.wr_new) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      addr_r <= wr_addr;
      hop_r  <= wr_hop;
    end
    if (ctl.wr_new || ctl.wr_stamp) begin
      stamp_r <= wr_stamp;
    end
  end

  assign valid = valid_r && (stamp_r == stamp_r);
  assign addr  = addr_r;
  assign hop   = hop_r;
endmodule
